/* hw/rtl/gfpc_pkg.sv */
`timescale 1ns / 1ps

package gfpc_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int CORDIC_ITER_DEF = 24;

  // Port and field widths.
  localparam int LAT_W      = 31;
  localparam int LON_W      = 32;
  localparam int IDX_W      = 6;
  localparam int DIST_W     = 31;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Iteration counter and fixed step counts of the square root and divider.
  localparam int ITER_W     = 5;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_BITS   = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;

  localparam logic [DIST_W-1:0]  RADIUS_RST = 31'd5000;
  localparam logic [COUNT_W-1:0] COUNT_RST  = 7'd0;

  // Fixed-point constants.
  localparam logic signed [33:0] GAIN_INV      = 34'sd1304065749;
  localparam logic signed [33:0] PI_Q20        = 34'sd3294199;
  localparam logic signed [33:0] UNITS_PER_RAD = 34'sd683565276;
  localparam logic signed [33:0] CM_PER_UNIT   = 34'sd4003017359;
  localparam logic signed [33:0] FULL_SCALE    = 34'sd5124095576;
  localparam logic signed [33:0] HALF_SCALE    = 34'sd2562047788;
  localparam logic signed [33:0] ONE_Q31       = 34'sh0_8000_0000;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_ANG_MUL, ST_ANG, ST_ROT, ST_MUL_YZ, ST_PI_Y, ST_MUL_XZ,
    ST_PI_X, ST_TRIG_FIN, ST_SQ1, ST_SQ2, ST_SQ3, ST_T, ST_TERM1, ST_TERM2,
    ST_TERM3, ST_HAV, ST_SQRT_INIT, ST_SQRT_ITER, ST_SQRT_FIN, ST_VEC_INIT,
    ST_VEC_ITER, ST_VNUM, ST_DIV_INIT, ST_DIV_ITER, ST_DIV_FIN, ST_DMUL, ST_DFIN,
    ST_CHECK, ST_FINAL
  } state_e;

  // Datapath operations.
  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_FIX, OP_READ, OP_ANG_MUL, OP_ANG, OP_ROT, OP_MUL_YZ,
    OP_PI_Y, OP_MUL_XZ, OP_PI_X, OP_TRIG_FIN, OP_SQ1, OP_SQ2, OP_SQ3, OP_T,
    OP_TERM1, OP_TERM2, OP_TERM3, OP_HAV, OP_SQRT_INIT, OP_SQRT_ITER, OP_SQRT_FIN,
    OP_VEC_INIT, OP_VEC_ITER, OP_VNUM, OP_DIV_INIT, OP_DIV_ITER, OP_DIV_FIN,
    OP_DMUL, OP_DFIN, OP_HIT, OP_FINAL
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [1:0]       sel;    // trig pass or square root pass
    logic [ITER_W-1:0] iter;  // CORDIC step index
    logic [IDX_W-1:0] entry;  // table slot under test
    logic             flag;   // a held match exists
  } cmd_t;

  typedef struct packed {
    logic hit;                // distance is within the radius
  } stat_t;

  // Arctangent of 2^-i in binary angle units.
  function automatic logic [31:0] atan_unit(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Clamp a value to the Q31 unit range.
  function automatic logic signed [32:0] clamp_q31(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = v;
    if (v > ONE_Q31) r = ONE_Q31;
    else if (v < -ONE_Q31) r = -ONE_Q31;
    return r[32:0];
  endfunction

  // Magnitude of a clamped Q31 value.
  function automatic logic [31:0] abs_q31(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

endpackage

/* hw/rtl/geofence_proximity_check.sv */
`timescale 1ns / 1ps
// A load transaction is taken while idle and gives no result.
// A fix runs each checked entry in turn through the shared CORDIC, square root and
// divider steps, then gives its last result.
// Each result is shown on a one-cycle strobe; the receiver cannot stall them.
// Reset clears control and the two configuration registers; the table is not cleared.
module geofence_proximity_check #(
  parameter int MAX_ENTRIES       = gfpc_pkg::MAX_ENTRIES_DEF,
  parameter int CORDIC_ITERATIONS = gfpc_pkg::CORDIC_ITER_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 opcode_i,
  input  logic [gfpc_pkg::IDX_W-1:0]           entry_index_i,
  input  logic signed [gfpc_pkg::LAT_W-1:0]    latitude_i,
  input  logic signed [gfpc_pkg::LON_W-1:0]    longitude_i,
  output logic                                 result_valid_o,
  output logic [gfpc_pkg::IDX_W-1:0]           match_index_o,
  output logic [gfpc_pkg::DIST_W-1:0]          distance_cm_o,
  output logic                                 matched_o,
  output logic                                 last_result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gfpc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gfpc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import gfpc_pkg::*;

  logic [DIST_W-1:0]  radius_q;
  logic [COUNT_W-1:0] count_q;
  cmd_t               cmd;
  stat_t              stat;

  assign cfg_ready_o = 1'b1;

  // Configuration registers, written by a config transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      count_q  <= COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_RADIUS) radius_q <= cfg_data_i;
      else if (cfg_index_i == CFG_COUNT) count_q <= cfg_data_i[COUNT_W-1:0];
    end
  end

  gfpc_ctrl #(
    .MAX_ENTRIES       (MAX_ENTRIES),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .opcode_i      (opcode_i),
    .entry_count_i (count_q),
    .stat_i        (stat),
    .busy          (busy),
    .cmd_o         (cmd)
  );

  gfpc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .entry_index_i (entry_index_i),
    .latitude_i    (latitude_i),
    .longitude_i   (longitude_i),
    .radius_i      (radius_q),
    .res_valid_o   (result_valid_o),
    .match_index_o (match_index_o),
    .distance_cm_o (distance_cm_o),
    .matched_o     (matched_o),
    .last_result_o (last_result_o)
  );

endmodule

/* hw/rtl/gfpc_ctrl.sv */
`timescale 1ns / 1ps

module gfpc_ctrl #(
  parameter int MAX_ENTRIES       = gfpc_pkg::MAX_ENTRIES_DEF,
  parameter int CORDIC_ITERATIONS = gfpc_pkg::CORDIC_ITER_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         opcode_i,
  input  logic [gfpc_pkg::COUNT_W-1:0] entry_count_i,
  input  gfpc_pkg::stat_t              stat_i,
  output logic                         busy,
  output gfpc_pkg::cmd_t               cmd_o
);
  import gfpc_pkg::*;

  localparam logic [ITER_W-1:0]  ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);
  localparam logic [ITER_W-1:0]  SQRT_LAST = ITER_W'(SQRT_STEPS - 1);
  localparam logic [ITER_W-1:0]  DIV_LAST  = ITER_W'(DIV_BITS - 1);
  localparam logic [COUNT_W-1:0] MAX_N     = COUNT_W'(MAX_ENTRIES);

  state_e             state_q, state_d;
  logic [ITER_W-1:0]  cnt_q, cnt_d;
  logic [1:0]         sel_q, sel_d;
  logic [COUNT_W-1:0] idx_q, idx_d;
  logic [COUNT_W-1:0] num_q, num_d;
  logic               pend_q, pend_d;
  logic [COUNT_W-1:0] num_sat;
  logic [COUNT_W-1:0] idx_inc;

  assign num_sat = (entry_count_i > MAX_N) ? MAX_N : entry_count_i;
  assign idx_inc = idx_q + COUNT_W'(1);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
      idx_q   <= '0;
      num_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      idx_q   <= idx_d;
      num_q   <= num_d;
      pend_q  <= pend_d;
    end
  end

  // Sequencing of one fix over all checked entries.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    idx_d   = idx_q;
    num_d   = num_q;
    pend_d  = pend_q;
    busy    = 1'b1;
    cmd_o.op    = OP_NONE;
    cmd_o.sel   = sel_q;
    cmd_o.iter  = cnt_q;
    cmd_o.entry = idx_q[IDX_W-1:0];
    cmd_o.flag  = pend_q;

    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (!opcode_i) begin
            cmd_o.op = OP_LOAD;
          end else begin
            cmd_o.op = OP_FIX;
            num_d    = num_sat;
            idx_d    = '0;
            pend_d   = 1'b0;
            state_d  = (num_sat == '0) ? ST_FINAL : ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.op = OP_READ;
        sel_d    = 2'd0;
        state_d  = ST_ANG_MUL;
      end
      ST_ANG_MUL: begin
        cmd_o.op = OP_ANG_MUL;
        state_d  = ST_ANG;
      end
      ST_ANG: begin
        cmd_o.op = OP_ANG;
        cnt_d    = '0;
        state_d  = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.op = OP_ROT;
        cnt_d    = cnt_q + ITER_W'(1);
        if (cnt_q == ITER_LAST) state_d = ST_MUL_YZ;
      end
      ST_MUL_YZ: begin
        cmd_o.op = OP_MUL_YZ;
        state_d  = ST_PI_Y;
      end
      ST_PI_Y: begin
        cmd_o.op = OP_PI_Y;
        state_d  = ST_MUL_XZ;
      end
      ST_MUL_XZ: begin
        cmd_o.op = OP_MUL_XZ;
        state_d  = ST_PI_X;
      end
      ST_PI_X: begin
        cmd_o.op = OP_PI_X;
        state_d  = ST_TRIG_FIN;
      end
      ST_TRIG_FIN: begin
        cmd_o.op = OP_TRIG_FIN;
        sel_d    = sel_q + 2'd1;
        state_d  = (sel_q == 2'd3) ? ST_SQ1 : ST_ANG_MUL;
      end
      ST_SQ1: begin
        cmd_o.op = OP_SQ1;
        state_d  = ST_SQ2;
      end
      ST_SQ2: begin
        cmd_o.op = OP_SQ2;
        state_d  = ST_SQ3;
      end
      ST_SQ3: begin
        cmd_o.op = OP_SQ3;
        state_d  = ST_T;
      end
      ST_T: begin
        cmd_o.op = OP_T;
        state_d  = ST_TERM1;
      end
      ST_TERM1: begin
        cmd_o.op = OP_TERM1;
        state_d  = ST_TERM2;
      end
      ST_TERM2: begin
        cmd_o.op = OP_TERM2;
        state_d  = ST_TERM3;
      end
      ST_TERM3: begin
        cmd_o.op = OP_TERM3;
        state_d  = ST_HAV;
      end
      ST_HAV: begin
        cmd_o.op = OP_HAV;
        sel_d    = 2'd0;
        state_d  = ST_SQRT_INIT;
      end
      ST_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = ST_SQRT_ITER;
      end
      ST_SQRT_ITER: begin
        cmd_o.op = OP_SQRT_ITER;
        cnt_d    = cnt_q + ITER_W'(1);
        if (cnt_q == SQRT_LAST) state_d = ST_SQRT_FIN;
      end
      ST_SQRT_FIN: begin
        cmd_o.op = OP_SQRT_FIN;
        sel_d    = 2'd1;
        state_d  = (sel_q == 2'd0) ? ST_SQRT_INIT : ST_VEC_INIT;
      end
      ST_VEC_INIT: begin
        cmd_o.op = OP_VEC_INIT;
        cnt_d    = '0;
        state_d  = ST_VEC_ITER;
      end
      ST_VEC_ITER: begin
        cmd_o.op = OP_VEC_ITER;
        cnt_d    = cnt_q + ITER_W'(1);
        if (cnt_q == ITER_LAST) state_d = ST_VNUM;
      end
      ST_VNUM: begin
        cmd_o.op = OP_VNUM;
        state_d  = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_DIV_ITER;
      end
      ST_DIV_ITER: begin
        cmd_o.op = OP_DIV_ITER;
        cnt_d    = cnt_q + ITER_W'(1);
        if (cnt_q == DIV_LAST) state_d = ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        cmd_o.op = OP_DIV_FIN;
        state_d  = ST_DMUL;
      end
      ST_DMUL: begin
        cmd_o.op = OP_DMUL;
        state_d  = ST_DFIN;
      end
      ST_DFIN: begin
        cmd_o.op = OP_DFIN;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        // A new match releases the one held before it.
        if (stat_i.hit) begin
          cmd_o.op = OP_HIT;
          pend_d   = 1'b1;
        end
        idx_d   = idx_inc;
        state_d = (idx_inc == num_q) ? ST_FINAL : ST_READ;
      end
      ST_FINAL: begin
        cmd_o.op = OP_FINAL;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/gfpc_datapath.sv */
`timescale 1ns / 1ps

module gfpc_datapath #(
  parameter int MAX_ENTRIES = gfpc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gfpc_pkg::cmd_t                      cmd_i,
  output gfpc_pkg::stat_t                     stat_o,
  input  logic [gfpc_pkg::IDX_W-1:0]          entry_index_i,
  input  logic signed [gfpc_pkg::LAT_W-1:0]   latitude_i,
  input  logic signed [gfpc_pkg::LON_W-1:0]   longitude_i,
  input  logic [gfpc_pkg::DIST_W-1:0]         radius_i,
  output logic                                res_valid_o,
  output logic [gfpc_pkg::IDX_W-1:0]          match_index_o,
  output logic [gfpc_pkg::DIST_W-1:0]         distance_cm_o,
  output logic                                matched_o,
  output logic                                last_result_o
);
  import gfpc_pkg::*;

  localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int MEM_W  = LAT_W + LON_W;
  localparam int DDEN_W = 34 + DIV_BITS;

  // Landmark table.
  logic [MEM_W-1:0] mem [MAX_ENTRIES];

  logic signed [LAT_W-1:0] fix_lat_q, rd_lat_q;
  logic signed [LON_W-1:0] fix_lon_q, rd_lon_q;

  // Shared multiplier and its product register.
  logic signed [36:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [70:0] mul_p, prod_q;

  // CORDIC registers, shared by rotation and vectoring.
  logic signed [33:0] cx_q, cy_q, cz_q, dx_q;
  logic               flip_q;
  logic signed [32:0] s1_q, s2_q, c1_q, c2_q;

  logic [62:0] s1sq_q, s2sq_q, hav_q;
  logic [31:0] t_q;
  logic [63:0] term_q;

  // Square root unit.
  logic [62:0] sv_q, sbit_q;
  logic [63:0] sr_q;
  logic [31:0] sqa_q, sqb_q;

  // Divider unit.
  logic [63:0]         dnum_q;
  logic [DDEN_W-1:0]   dden_q;
  logic [DIV_BITS-1:0] quot_q;
  logic                dneg_q;

  logic [DIST_W-1:0] dist_q;
  logic [IDX_W-1:0]  pend_idx_q;
  logic [DIST_W-1:0] pend_dist_q;

  logic              res_valid_q, res_match_q, res_last_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic [DIST_W-1:0] res_dist_q;

  // Operand preparation.
  logic signed [32:0] lat_e, lat_f, lon_e, lon_f, ang_src;
  logic signed [33:0] at_s, sh_x, sh_y, trig_x, trig_y;
  logic signed [32:0] trig_s, trig_c;
  logic [63:0]        ang_sum;
  logic [31:0]        ang, ang_q1, ang_f;
  logic [31:0]        zc;
  logic [63:0]        sq_sum;
  logic [64:0]        hav_sum;
  logic [63:0]        hav_new;
  logic [64:0]        dist_sum;
  logic signed [70:0] num_abs;
  logic signed [33:0] quot_s;

  assign lat_e = 33'(rd_lat_q);
  assign lat_f = 33'(fix_lat_q);
  assign lon_e = 33'(rd_lon_q);
  assign lon_f = 33'(fix_lon_q);

  always_comb begin
    unique case (cmd_i.sel)
      2'd0:    ang_src = lat_e - lat_f;
      2'd1:    ang_src = lon_e - lon_f;
      2'd2:    ang_src = lat_f;
      default: ang_src = lat_e;
    endcase
  end

  assign at_s = {2'b00, atan_unit(cmd_i.iter)};
  assign sh_x = cx_q >>> cmd_i.iter;
  assign sh_y = cy_q >>> cmd_i.iter;

  // Binary angle with rounding, folded into the right half plane.
  assign ang_sum = prod_q[63:0] + 64'h8000_0000;
  assign ang     = ang_sum[63:32];
  assign ang_q1  = ang + 32'h4000_0000;
  assign ang_f   = {ang[31] ^ ang_q1[31], ang[30:0]};

  // First-order residual correction, then undo the fold.
  always_comb begin
    trig_x = cx_q - dx_q;
    trig_y = cy_q + 34'(prod_q >>> 35);
    if (flip_q) begin
      trig_x = -trig_x;
      trig_y = -trig_y;
    end
    trig_s = clamp_q31(trig_y);
    trig_c = clamp_q31(trig_x);
  end

  assign sq_sum  = sr_q + {1'b0, sbit_q};
  assign hav_sum = {1'b0, s1sq_q} + {1'b0, term_q};

  // Haversine term, clamped to [0, 1] in Q62.
  always_comb begin
    if (c1_q[32] != c2_q[32]) begin
      hav_new = (term_q > {1'b0, s1sq_q}) ? 64'd0 : ({1'b0, s1sq_q} - term_q);
    end else begin
      hav_new = hav_sum[63:0];
    end
    if (hav_sum[64] || hav_new > 64'h4000_0000_0000_0000) begin
      hav_new = 64'h4000_0000_0000_0000;
    end
  end

  // Central angle clamped to [0, pi].
  always_comb begin
    if (cz_q[33]) zc = '0;
    else if (cz_q > ONE_Q31) zc = 32'h8000_0000;
    else zc = cz_q[31:0];
  end

  assign dist_sum = {1'b0, prod_q[63:0]} + 65'h8000_0000;
  assign num_abs  = prod_q[70] ? -prod_q : prod_q;
  assign quot_s   = {2'b00, quot_q};

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_ANG_MUL: begin
        mul_a = 37'(ang_src);
        mul_b = cmd_i.sel[1] ? FULL_SCALE : HALF_SCALE;
      end
      OP_MUL_YZ: begin
        mul_a = 37'(cy_q);
        mul_b = cz_q;
      end
      OP_MUL_XZ: begin
        mul_a = 37'(cx_q);
        mul_b = cz_q;
      end
      OP_PI_Y, OP_PI_X: begin
        mul_a = 37'(prod_q >>> 16);
        mul_b = PI_Q20;
      end
      OP_SQ1: begin
        mul_a = {5'b0, abs_q31(s1_q)};
        mul_b = {2'b0, abs_q31(s1_q)};
      end
      OP_SQ2: begin
        mul_a = {5'b0, abs_q31(s2_q)};
        mul_b = {2'b0, abs_q31(s2_q)};
      end
      OP_SQ3: begin
        mul_a = {5'b0, abs_q31(c1_q)};
        mul_b = {2'b0, abs_q31(c2_q)};
      end
      OP_TERM1: begin
        mul_a = {5'b0, s2sq_q[62:31]};
        mul_b = {2'b0, t_q};
      end
      OP_TERM2: begin
        mul_a = {6'b0, s2sq_q[30:0]};
        mul_b = {2'b0, t_q};
      end
      OP_VNUM: begin
        mul_a = 37'(cy_q);
        mul_b = UNITS_PER_RAD;
      end
      OP_DMUL: begin
        mul_a = {4'b0, zc, 1'b0};
        mul_b = CM_PER_UNIT;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Table write on a load transaction, registered read per entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && 7'(entry_index_i) < 7'(MAX_ENTRIES)) begin
      mem[entry_index_i[AW-1:0]] <= {latitude_i, longitude_i};
    end
    if (cmd_i.op == OP_READ) begin
      {rd_lat_q, rd_lon_q} <= mem[cmd_i.entry[AW-1:0]];
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_FIX: begin
        fix_lat_q <= latitude_i;
        fix_lon_q <= longitude_i;
      end
      OP_ANG_MUL, OP_MUL_YZ, OP_PI_Y, OP_PI_X, OP_SQ1, OP_TERM1, OP_VNUM,
      OP_DMUL: begin
        prod_q <= mul_p;
      end
      OP_ANG: begin
        flip_q <= ang_q1[31];
        cx_q   <= GAIN_INV;
        cy_q   <= '0;
        cz_q   <= 34'($signed(ang_f));
      end
      OP_ROT: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - sh_y;
          cy_q <= cy_q + sh_x;
          cz_q <= cz_q - at_s;
        end else begin
          cx_q <= cx_q + sh_y;
          cy_q <= cy_q - sh_x;
          cz_q <= cz_q + at_s;
        end
      end
      OP_MUL_XZ: begin
        dx_q   <= 34'(prod_q >>> 35);
        prod_q <= mul_p;
      end
      OP_TRIG_FIN: begin
        unique case (cmd_i.sel)
          2'd0:    s1_q <= trig_s;
          2'd1:    s2_q <= trig_s;
          2'd2:    c1_q <= trig_c;
          default: c2_q <= trig_c;
        endcase
      end
      OP_SQ2: begin
        s1sq_q <= prod_q[62:0];
        prod_q <= mul_p;
      end
      OP_SQ3: begin
        s2sq_q <= prod_q[62:0];
        prod_q <= mul_p;
      end
      OP_T: begin
        t_q <= 32'((prod_q[62:0] + 63'h4000_0000) >> 31);
      end
      OP_TERM2: begin
        term_q <= prod_q[63:0];
        prod_q <= mul_p;
      end
      OP_TERM3: begin
        term_q <= term_q + {31'b0, prod_q[63:31]};
      end
      OP_HAV: begin
        hav_q <= hav_new[62:0];
      end
      OP_SQRT_INIT: begin
        sv_q   <= (cmd_i.sel == 2'd0) ? (63'h4000_0000_0000_0000 - hav_q) : hav_q;
        sr_q   <= '0;
        sbit_q <= 63'h4000_0000_0000_0000;
      end
      OP_SQRT_ITER: begin
        if ({1'b0, sv_q} >= sq_sum) begin
          sv_q <= 63'({1'b0, sv_q} - sq_sum);
          sr_q <= (sr_q >> 1) + {1'b0, sbit_q};
        end else begin
          sr_q <= sr_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      OP_SQRT_FIN: begin
        if (cmd_i.sel == 2'd0) sqa_q <= sr_q[31:0];
        else sqb_q <= sr_q[31:0];
      end
      OP_VEC_INIT: begin
        cx_q <= {2'b00, sqa_q};
        cy_q <= {2'b00, sqb_q};
        cz_q <= '0;
      end
      OP_VEC_ITER: begin
        if (!cy_q[33]) begin
          cx_q <= cx_q + sh_y;
          cy_q <= cy_q - sh_x;
          cz_q <= cz_q + at_s;
        end else begin
          cx_q <= cx_q - sh_y;
          cy_q <= cy_q + sh_x;
          cz_q <= cz_q - at_s;
        end
      end
      OP_DIV_INIT: begin
        dneg_q <= prod_q[70];
        dnum_q <= num_abs[63:0];
        dden_q <= {{DIV_BITS{1'b0}}, cx_q} << (DIV_BITS - 1);
        quot_q <= '0;
      end
      OP_DIV_ITER: begin
        if ({{(DDEN_W-64){1'b0}}, dnum_q} >= dden_q) begin
          dnum_q <= dnum_q - dden_q[63:0];
          quot_q <= {quot_q[DIV_BITS-2:0], 1'b1};
        end else begin
          quot_q <= {quot_q[DIV_BITS-2:0], 1'b0};
        end
        dden_q <= dden_q >> 1;
      end
      OP_DIV_FIN: begin
        if (!cx_q[33] && cx_q != '0) begin
          cz_q <= dneg_q ? (cz_q - quot_s) : (cz_q + quot_s);
        end
      end
      OP_DFIN: begin
        dist_q <= (dist_sum[64:32] > 33'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                     : dist_sum[62:32];
      end
      OP_HIT: begin
        pend_idx_q  <= cmd_i.entry;
        pend_dist_q <= dist_q;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.hit = (dist_q <= radius_i);

  // Result payload: a held match is released by the next one or by the end.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_HIT) begin
      res_idx_q   <= pend_idx_q;
      res_dist_q  <= pend_dist_q;
      res_match_q <= 1'b1;
      res_last_q  <= 1'b0;
    end else if (cmd_i.op == OP_FINAL) begin
      res_idx_q   <= cmd_i.flag ? pend_idx_q : '0;
      res_dist_q  <= cmd_i.flag ? pend_dist_q : '0;
      res_match_q <= cmd_i.flag;
      res_last_q  <= 1'b1;
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.op == OP_FINAL) || (cmd_i.op == OP_HIT && cmd_i.flag);
    end
  end

  assign res_valid_o   = res_valid_q;
  assign match_index_o = res_idx_q;
  assign distance_cm_o = res_dist_q;
  assign matched_o     = res_match_q;
  assign last_result_o = res_last_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import gfpc_pkg::*;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_FIX  = 1'b1;
  localparam int   TABLE_DEPTH = 64;
  localparam int   ROT_STEPS   = 24;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [DIST_W-1:0] RADIUS_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [IDX_W-1:0]  slot;
    logic [DIST_W-1:0] dist_cm;
    logic              hit;
    logic              last;
  } fence_result_t;

  // Geofence scoreboard: keeps its own copy of the landmark table and registers,
  // computes haversine distances and holds the matches still to come.
  class fence_scoreboard;
    int errors;
    logic [DIST_W-1:0] radius;
    logic [COUNT_W-1:0] count;
    longint lat_tab[TABLE_DEPTH];
    longint lon_tab[TABLE_DEPTH];
    fence_result_t pending[$];
    longint atan_tab[32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};

    function new();
      errors = 0;
      radius = RADIUS_RST;
      count  = COUNT_RST;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
      if (idx == CFG_RADIUS) radius = v;
      else if (idx == CFG_COUNT) count = v[COUNT_W-1:0];
    endfunction

    function logic [31:0] to_angle(input longint d, input longint unsigned scale);
      logic [63:0] p;
      p = longint'(d) * scale + 64'h8000_0000;
      return p[63:32];
    endfunction

    function longint clamp_unit(input longint v);
      if (v > 64'sh8000_0000) return 64'sh8000_0000;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
    endfunction

    // Rotation-mode CORDIC with a first-order fix for the leftover angle.
    function void sin_cos(input logic [31:0] ang, output longint sn, output longint cs);
      logic [31:0] t;
      logic flip;
      longint x, y, z, dx, dy;
      t = ang + 32'h4000_0000;
      flip = t[31];
      if (flip) ang = ang - 32'h8000_0000;
      z = $signed(ang);
      x = 1304065749;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      dx = (((y * z) >>> 16) * 3294199) >>> 35;
      dy = (((x * z) >>> 16) * 3294199) >>> 35;
      x -= dx;
      y += dy;
      if (flip) begin
        x = -x; y = -y;
      end
      sn = clamp_unit(y);
      cs = clamp_unit(x);
    endfunction

    function longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    // Vectoring-mode CORDIC: angle of (x, y) in binary angle units.
    function longint vector_angle(input longint x, input longint y);
      longint z, nx;
      z = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i); y -= x >>> i; z += atan_tab[i];
        end else begin
          nx = x - (y >>> i); y += x >>> i; z -= atan_tab[i];
        end
        x = nx;
      end
      if (x > 0) z += (y * 683565276) / x;
      return z;
    endfunction

    function logic [DIST_W-1:0] haversine_cm(input longint lat1, input longint lon1,
                                             input longint lat2, input longint lon2);
      longint s1, s2, c1, c2, junk, z;
      longint unsigned a1, a2, s1sq, s2sq, cprod, t, term, hav, dcm;
      logic neg;
      sin_cos(to_angle(lat2 - lat1, 64'd2562047788), s1, junk);
      sin_cos(to_angle(lon2 - lon1, 64'd2562047788), s2, junk);
      sin_cos(to_angle(lat1, 64'd5124095576), junk, c1);
      sin_cos(to_angle(lat2, 64'd5124095576), junk, c2);
      a1 = (s1 < 0) ? -s1 : s1;
      a2 = (s2 < 0) ? -s2 : s2;
      s1sq = a1 * a1;
      s2sq = a2 * a2;
      neg = (c1 < 0) != (c2 < 0);
      cprod = longint'((c1 < 0) ? -c1 : c1) * longint'((c2 < 0) ? -c2 : c2);
      t = (cprod + 64'h4000_0000) >> 31;
      term = (s2sq >> 31) * t + (((s2sq & 64'h7FFF_FFFF) * t) >> 31);
      if (neg) hav = (term > s1sq) ? 0 : s1sq - term;
      else hav = s1sq + term;
      if (hav > 64'h4000_0000_0000_0000) hav = 64'h4000_0000_0000_0000;
      z = vector_angle(int_sqrt(64'h4000_0000_0000_0000 - hav), int_sqrt(hav));
      if (z < 0) z = 0;
      if (z > 64'sh8000_0000) z = 64'sh8000_0000;
      dcm = ((2 * z) * 64'd4003017359 + 64'h8000_0000) >> 32;
      return (dcm > 64'h7FFF_FFFF) ? RADIUS_MAX : dcm[DIST_W-1:0];
    endfunction

    // Append one expected result behind those already queued.
    function void add_expected(input fence_result_t r);
      pending.insert(pending.size(), r);
    endfunction

    // An accepted transaction: a load updates the table, a fix queues its matches and marks the last.
    function void note_item(input logic op, input logic [IDX_W-1:0] slot,
                            input logic signed [LAT_W-1:0] lat,
                            input logic signed [LON_W-1:0] lon);
      int n;
      fence_result_t r;
      logic [DIST_W-1:0] d;
      if (op == OPC_LOAD) begin
        lat_tab[slot] = lat;
        lon_tab[slot] = lon;
        return;
      end
      n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      for (int i = 0; i < n; i++) begin
        d = haversine_cm(lat, lon, lat_tab[i], lon_tab[i]);
        if (d <= radius) begin
          r = '{slot: IDX_W'(i), dist_cm: d, hit: 1'b1, last: 1'b0};
          add_expected(r);
        end
      end
      if (pending.size() == 0 || pending[$].last == 1'b1) begin
        r = '{slot: '0, dist_cm: '0, hit: 1'b0, last: 1'b1};
        add_expected(r);
      end else pending[$].last = 1'b1;
    endfunction

    task check_result(input fence_result_t got);
      fence_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result slot %0d dist %0d", got.slot, got.dist_cm));
        return;
      end
      want = pending.pop_front();
      if (got.slot != want.slot)
        report($sformatf("match_index %0d, want %0d", got.slot, want.slot));
      if (got.dist_cm != want.dist_cm)
        report($sformatf("distance_cm %0d, want %0d (slot %0d)", got.dist_cm,
                         want.dist_cm, want.slot));
      if (got.hit != want.hit)
        report($sformatf("matched %0b, want %0b", got.hit, want.hit));
      if (got.last != want.last)
        report($sformatf("last_result %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic opcode_i = OPC_LOAD;
  logic [IDX_W-1:0] entry_index_i = '0;
  logic signed [LAT_W-1:0] latitude_i = '0;
  logic signed [LON_W-1:0] longitude_i = '0;
  logic result_valid_o;
  logic [IDX_W-1:0] match_index_o;
  logic [DIST_W-1:0] distance_cm_o;
  logic matched_o;
  logic last_result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_RADIUS;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  fence_scoreboard sb = new();
  longint cycles = 0;
  int sent = 0;
  bit written[TABLE_DEPTH];

  geofence_proximity_check dut (.*);

  always #10 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Observe accepted transactions and strobed results.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      sb.note_item(opcode_i, entry_index_i, latitude_i, longitude_i);
    if (rst_ni && result_valid_o)
      sb.check_result(fence_result_t'{slot: match_index_o, dist_cm: distance_cm_o,
                                      hit: matched_o, last: last_result_o});
  end

  // Send one transaction, idling at random outside the quiet stretch.
  task send_item(input logic op, input logic [IDX_W-1:0] slot,
                 input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon);
    if ((sent < 60 || sent > 110) && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    entry_index_i <= slot;
    latitude_i <= lat;
    longitude_i <= lon;
    do @(posedge clk_i); while (busy);
    if (op == OPC_LOAD) written[slot] = 1'b1;
    sent++;
  endtask

  // Let the block drain, then write one register.
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
    cfg_valid_i <= 1'b0;
  endtask

  function int written_prefix();
    int p;
    p = 0;
    while (p < TABLE_DEPTH && written[p]) p++;
    return p;
  endfunction

  task random_fix(input int n);
    int k;
    if (n > 0 && $urandom_range(99) < 70) begin
      k = $urandom_range(n - 1);
      send_item(OPC_FIX, IDX_W'($urandom),
                LAT_W'(sb.lat_tab[k] + $signed($urandom_range(40000)) - 20000),
                LON_W'(sb.lon_tab[k] + $signed($urandom_range(40000)) - 20000));
    end else if ($urandom_range(1)) begin
      send_item(OPC_FIX, IDX_W'($urandom),
                LAT_W'($signed($urandom_range(1800000000)) - 900000000),
                LON_W'($urandom_range(3600000000) - 1800000000));
    end else send_item(OPC_FIX, IDX_W'($urandom), LAT_W'($urandom), LON_W'($urandom));
  endtask

  task random_load();
    int p;
    p = written_prefix();
    if (p < TABLE_DEPTH && $urandom_range(1))
      send_item(OPC_LOAD, IDX_W'(p),
                LAT_W'($signed($urandom_range(1800000000)) - 900000000),
                LON_W'($urandom_range(3600000000) - 1800000000));
    else send_item(OPC_LOAD, IDX_W'($urandom), LAT_W'($urandom), LON_W'($urandom));
  endtask

  initial begin
    int n, phase, pick;
    logic [DIST_W-1:0] rad;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, field extremes, exact hit and antipodes.
    send_item(OPC_FIX, 6'd0, 31'sd0, 32'sd0);
    send_item(OPC_LOAD, 6'd0, 31'sd900000000, 32'sd1800000000);
    send_item(OPC_LOAD, 6'd1, -31'sd900000000, -32'sd1800000000);
    send_item(OPC_LOAD, 6'd2, 31'sd0, 32'sd0);
    send_item(OPC_LOAD, 6'd3, 31'h3FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OPC_LOAD, 6'd63, 31'h4000_0000, 32'h8000_0000);
    write_reg(CFG_COUNT, CFG_DATA_W'(4));
    write_reg(CFG_RADIUS, RADIUS_MAX);
    send_item(OPC_FIX, 6'd0, 31'sd0, 32'sd0);
    send_item(OPC_FIX, 6'd63, 31'sd900000000, 32'sd1800000000);
    send_item(OPC_FIX, 6'd0, 31'h4000_0000, 32'h8000_0000);
    write_reg(CFG_RADIUS, '0);
    send_item(OPC_FIX, 6'd0, 31'sd0, 32'sd0);
    send_item(OPC_FIX, 6'd0, 31'sd0, 32'sd1);
    write_reg(CFG_RADIUS, 31'd200000);
    send_item(OPC_FIX, 6'd0, 31'sd900000000, -32'sd1800000000);
    send_item(OPC_FIX, 6'd0, 31'sd1000, 32'sd1000);
    send_item(OPC_FIX, 6'd0, -31'sd899990000, -32'sd1799990000);

    // Random phases; one late phase fills the whole table for the full count.
    phase = 0;
    while (sent < 150) begin
      pick = $urandom_range(4);
      rad = (pick == 0) ? '0 : (pick == 1) ? RADIUS_MAX :
            (pick == 2) ? DIST_W'($urandom) : DIST_W'($urandom_range(1000000));
      write_reg(CFG_RADIUS, rad);
      if (phase == 6) begin
        for (int s = 0; s < TABLE_DEPTH; s++)
          if (!written[s]) send_item(OPC_LOAD, IDX_W'(s), LAT_W'($urandom), LON_W'($urandom));
      end
      n = written_prefix();
      if (n == TABLE_DEPTH && phase >= 6 && phase <= 8) begin
        write_reg(CFG_COUNT,
                  CFG_DATA_W'((phase == 7) ? 127 : 64 + $urandom_range(phase - 6)));
        repeat (3) random_fix(TABLE_DEPTH);
      end else begin
        n = $urandom_range((n < 8) ? n : 8);
        write_reg(CFG_COUNT, CFG_DATA_W'(n));
        repeat (12) begin
          if ($urandom_range(99) < 30) random_load();
          else random_fix(n);
        end
      end
      phase++;
    end

    // Drain and finish once no expected result is left.
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
